@@ sv/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES package
// Shared types, the S-box and the column mixing helper for the AES cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYREQ,
    ST_KEYHI,
    ST_KEYLO,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_ENC = 1'b1;

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One full cipher round body without the key: SubBytes, ShiftRows and,
  // when asked, MixColumns. Byte 0 sits in bits 127:120.
  function automatic logic [127:0] round_body(input logic [127:0] s, input logic do_mix);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) a[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = sbox(a[r + 4*((c + r) & 3)]);
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int r = 0; r < 4; r++)
        m[4*c+r] = t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c+((r+1)&3)]);
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = do_mix ? m[i] : t[i];
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/aes_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// AES block encryption
// Iterative AES core: one shared round unit reused for every round, round
// keys read as two halves from a key RAM.
// ----------------------------------------------------------------------------
// Sequencing: each round needs two key RAM reads through the single read
// port, plus one round unit pass.
// Throughput: one transaction at a time; a key load leaves the core idle.
// Reset: the sequencer returns to idle, num_rounds to 10; key RAM is not
// cleared and its entries are undefined until loaded.
`default_nettype none

module aes_block_encrypt #(
  parameter int MAX_ROUNDS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [4:0]  key_slot,
  input  wire logic [63:0] data_hi,
  input  wire logic [63:0] data_lo,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      cipher_hi,
  output logic [63:0]      cipher_lo
);

  localparam int Slots = 2 * (MAX_ROUNDS + 1);
  localparam int AW = $clog2(Slots);
  localparam int RW = $clog2(MAX_ROUNDS + 1);

  aes_pkg::state_t state, state_next;
  logic [3:0]   num_rounds;
  logic [RW-1:0] nr;
  logic [RW-1:0] rnd;
  logic [127:0] blk;
  logic [63:0]  key_hi;
  logic [AW-1:0] raddr;
  logic [63:0]  rdata;
  logic         we;
  logic         in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == aes_pkg::ST_IDLE);
  assign out_valid = (state == aes_pkg::ST_DONE);
  assign cipher_hi = blk[127:64];
  assign cipher_lo = blk[63:0];
  assign in_acc    = in_valid && in_ready;
  assign we = in_acc && (kind == aes_pkg::KIND_KEY) && ({1'b0, key_slot} < 6'(Slots));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rounds <= 4'd10;
    end else if (cfg_valid && cfg_ready) begin
      num_rounds <= cfg_data;
    end
  end

  // Clamp the round count into the supported range.
  always_comb begin
    if (num_rounds == 4'd0) begin
      nr = RW'(1);
    end else if (32'(num_rounds) > MAX_ROUNDS) begin
      nr = RW'(MAX_ROUNDS);
    end else begin
      nr = RW'(num_rounds);
    end
  end

  aes_ram #(.WIDTH(64), .DEPTH(Slots)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (key_slot[AW-1:0]),
    .wdata (data_hi),
    .raddr (raddr),
    .rdata (rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and key read address.
  always_comb begin
    state_next = state;
    raddr = AW'({rnd, 1'b1});
    unique case (state)
      aes_pkg::ST_IDLE: begin
        raddr = '0;
        if (in_acc && kind == aes_pkg::KIND_ENC) begin
          state_next = aes_pkg::ST_KEYREQ;
        end
      end
      aes_pkg::ST_KEYREQ: begin
        raddr = AW'({rnd, 1'b0});
        state_next = aes_pkg::ST_KEYHI;
      end
      aes_pkg::ST_KEYHI: begin
        state_next = aes_pkg::ST_KEYLO;
      end
      aes_pkg::ST_KEYLO: begin
        state_next = (rnd == nr) ? aes_pkg::ST_DONE : aes_pkg::ST_ROUND;
      end
      aes_pkg::ST_ROUND: begin
        state_next = aes_pkg::ST_KEYREQ;
      end
      aes_pkg::ST_DONE: begin
        if (out_ready) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      default: state_next = aes_pkg::ST_IDLE;
    endcase
  end

  // Datapath: load block, add keys, run the shared round unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else begin
      unique case (state)
        aes_pkg::ST_IDLE: begin
          rnd <= '0;
          if (in_acc) begin
            blk <= {data_hi, data_lo};
          end
        end
        aes_pkg::ST_KEYHI: key_hi <= rdata;
        aes_pkg::ST_KEYLO: begin
          blk <= blk ^ {key_hi, rdata};
          rnd <= rnd + RW'(1);
        end
        aes_pkg::ST_ROUND: blk <= aes_pkg::round_body(blk, rnd != nr);
        default: ;
      endcase
    end
  end

  // Result holds while waiting to be taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blk))
    else $error("result changed while stalled");
  // No input is taken while busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != aes_pkg::ST_IDLE |-> !in_ready)
    else $error("ready while busy");
  // Round counter never passes the clamped count while rounds are running.
  a_rnd: assert property (@(posedge clk) disable iff (rst)
    rnd <= nr || state == aes_pkg::ST_IDLE || state == aes_pkg::ST_DONE)
    else $error("round counter overrun");

endmodule

`default_nettype wire

@@ sv/aes_ram.sv @@
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 30
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ tb/sv/aes_block_encrypt_tb.sv @@
// ----------------------------------------------------------------------------
// AES block encryption testbench
// Loads round keys, changes the round count between phases and encrypts
// directed and random blocks with random idling on both channels. Each
// ciphertext is checked against a predictor of the cipher built into the
// testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module aes_block_encrypt_tb;

  localparam int KEY_ENTRIES = 30;
  localparam int TOP_ROUNDS  = 14;

  typedef struct packed {
    logic        kind;
    logic [4:0]  key_slot;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } block_req_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = aes_pkg::KIND_KEY;
  logic [4:0]  key_slot = '0;
  logic [63:0] data_hi = '0;
  logic [63:0] data_lo = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;

  aes_block_encrypt uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .key_slot(key_slot),
    .data_hi(data_hi), .data_lo(data_lo),
    .out_valid(out_valid), .out_ready(out_ready),
    .cipher_hi(cipher_hi), .cipher_lo(cipher_lo)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: shadow key store and round count.
  logic [63:0] key_shadow [KEY_ENTRIES];
  logic [3:0]  rounds_shadow = 4'd10;

  block_req_t pending_blocks [$];
  cipher_t    expected_ciphers [$];
  int         mismatches = 0;
  int         ciphers_seen = 0;
  int         encrypts_sent = 0;
  int         keyloads_sent = 0;
  bit         quiet_phase = 1'b0;
  bit         hold_output = 1'b0;
  bit         in_taken = 1'b0;

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[b];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt one block with the shadow keys; byte 0 sits in the top bits.
  function automatic cipher_t encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
    logic [7:0] st [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] blk;
    logic [127:0] rk;
    int nr;
    blk = {hi, lo};
    nr = (rounds_shadow == 0) ? 1 : (rounds_shadow > TOP_ROUNDS ? TOP_ROUNDS : rounds_shadow);
    rk = {key_shadow[0], key_shadow[1]};
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8] ^ rk[127 - 8*i -: 8];
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[w + 4*c] = sub_byte(st[w + 4*((c + w) & 3)]);
      if (r < nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      rk = {key_shadow[2*r], key_shadow[2*r+1]};
      for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[127 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = st[i];
    return '{hi: blk[127:64], lo: blk[63:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  // Driver: offers queued transactions with random idle bursts. A new
  // transaction is only put up once the current one has been accepted.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          kind     <= pending_blocks[0].kind;
          key_slot <= pending_blocks[0].key_slot;
          data_hi  <= pending_blocks[0].data_hi;
          data_lo  <= pending_blocks[0].data_lo;
          in_valid <= 1'b1;
          void'(pending_blocks.pop_front());
          if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Prediction at acceptance of each input transaction.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      in_taken = 1'b1;
      if (kind == aes_pkg::KIND_ENC) begin
        expected_ciphers.push_back(encrypt_block(data_hi, data_lo));
        encrypts_sent++;
      end else begin
        if (key_slot < KEY_ENTRIES) begin
          key_shadow[key_slot] = data_hi;
        end
        keyloads_sent++;
      end
    end
  end

  // Monitor: checks each accepted ciphertext against the oldest prediction.
  always @(posedge clk) begin
    cipher_t want;
    if (!rst && out_valid && out_ready) begin
      ciphers_seen++;
      if (expected_ciphers.size() == 0) begin
        report_mismatch("unexpected cipher_hi", cipher_hi, 64'hx);
      end else begin
        want = expected_ciphers.pop_front();
        if (cipher_hi !== want.hi) report_mismatch("cipher_hi", cipher_hi, want.hi);
        if (cipher_lo !== want.lo) report_mismatch("cipher_lo", cipher_lo, want.lo);
      end
    end
  end

  // Receiver ready: random stall bursts, or a long hold when asked.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst || hold_output) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic block_req_t key_item(input int slot, input logic [63:0] v);
    return '{kind: aes_pkg::KIND_KEY, key_slot: slot[4:0], data_hi: v,
             data_lo: {$urandom, $urandom}};
  endfunction

  function automatic block_req_t enc_item(input logic [63:0] hi, input logic [63:0] lo);
    return '{kind: aes_pkg::KIND_ENC, key_slot: 5'($urandom), data_hi: hi, data_lo: lo};
  endfunction

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_ciphers.size() > 0)
      @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_rounds(input logic [3:0] n);
    @(negedge clk);
    cfg_data  <= n;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rounds_shadow = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all_keys(input bit extremes);
    logic [63:0] v;
    for (int s = 0; s < KEY_ENTRIES; s++) begin
      v = extremes ? ((s % 2) ? 64'hffff_ffff_ffff_ffff : 64'h0) : {$urandom, $urandom};
      pending_blocks.push_back(key_item(s, v));
    end
  endtask

  task automatic random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        pending_blocks.push_back(key_item($urandom_range(0, 31), {$urandom, $urandom}));
      else
        pending_blocks.push_back(enc_item({$urandom, $urandom}, {$urandom, $urandom}));
    end
  endtask

  initial begin
    logic [3:0] settings [8];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme keys and data at the reset round count.
    load_all_keys(1'b1);
    pending_blocks.push_back(enc_item(64'h0, 64'h0));
    pending_blocks.push_back(enc_item('1, '1));
    pending_blocks.push_back(enc_item(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff));
    // Loads beyond the store depth must leave it untouched.
    pending_blocks.push_back(key_item(30, 64'hdead_beef_0000_0001));
    pending_blocks.push_back(key_item(31, 64'h1234_5678_9abc_def0));
    pending_blocks.push_back(enc_item(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef));
    wait_drained();

    // Round counts of zero and above the maximum are clamped.
    settings = '{4'd0, 4'd15, 4'd1, 4'd12, 4'd14, 4'd13, 4'd3, 4'd10};
    foreach (settings[k]) begin
      write_rounds(settings[k]);
      load_all_keys(1'b0);
      pending_blocks.push_back(enc_item('1, 64'h0));
      if (k == 3) begin
        // Hold the output so the core fills and back-pressures its input.
        hold_output = 1'b1;
        random_mix(10);
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
      end
      random_mix(110);
      wait_drained();
    end

    // Final stretch without idling.
    quiet_phase = 1'b1;
    random_mix(60);
    wait_drained();

    $display("Covered %0d key loads and %0d encryptions over round counts 0 to 15.",
             keyloads_sent, encrypts_sent);
    $display("Checked %0d ciphertexts, %0d mismatches.", ciphers_seen, mismatches);
    if (mismatches == 0 && expected_ciphers.size() == 0)
      $display("aes_block_encrypt regression: pass");
    else
      $display("aes_block_encrypt regression: fail");
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Timeout with %0d ciphertexts outstanding.", expected_ciphers.size());
    $display("aes_block_encrypt regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
